>>> rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg: shared definitions for the serial decimal display
// Opcodes, microcode word layout, control ROM, dispatch and segment table.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int DIGITS      = 4;
  localparam int SCAN_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int STORE_DEPTH = 4;
  localparam int COUNT_MAX   = 5;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_IDLE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_STORE,
    A_CLEAR,
    A_MAC,
    A_COMMIT,
    A_LOAD,
    A_DIV,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_IDX_DONE,
    C_IDX_AT_K,
    C_WAIT_OUT
  } cond_t;

  typedef logic [3:0] pc_t;

  localparam pc_t STEP_IDLE      = 4'd0;
  localparam pc_t STEP_BYTE      = 4'd1;
  localparam pc_t STEP_CONV      = 4'd2;
  localparam pc_t STEP_CONV_TEST = 4'd3;
  localparam pc_t STEP_CONV_MAC  = 4'd4;
  localparam pc_t STEP_CONV_END  = 4'd5;
  localparam pc_t STEP_SCAN      = 4'd6;
  localparam pc_t STEP_SCAN_TEST = 4'd7;
  localparam pc_t STEP_SCAN_DIV  = 4'd8;
  localparam pc_t STEP_SCAN_EMIT = 4'd9;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic accept;
    op_t  op;
    logic idx_done;
    logic idx_at_k;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    act_t act;
    logic busy;
  } seq_ctrl_t;

  // control store
  function automatic uword_t ucode(pc_t pc);
    uword_t uw;
    case (pc)
      STEP_IDLE:      uw = '{A_NONE,   C_DISPATCH, STEP_IDLE};
      STEP_BYTE:      uw = '{A_STORE,  C_JUMP,     STEP_IDLE};
      STEP_CONV:      uw = '{A_CLEAR,  C_NEXT,     STEP_IDLE};
      STEP_CONV_TEST: uw = '{A_NONE,   C_IDX_DONE, STEP_CONV_END};
      STEP_CONV_MAC:  uw = '{A_MAC,    C_JUMP,     STEP_CONV_TEST};
      STEP_CONV_END:  uw = '{A_COMMIT, C_JUMP,     STEP_IDLE};
      STEP_SCAN:      uw = '{A_LOAD,   C_NEXT,     STEP_IDLE};
      STEP_SCAN_TEST: uw = '{A_NONE,   C_IDX_AT_K, STEP_SCAN_EMIT};
      STEP_SCAN_DIV:  uw = '{A_DIV,    C_JUMP,     STEP_SCAN_TEST};
      STEP_SCAN_EMIT: uw = '{A_EMIT,   C_WAIT_OUT, STEP_IDLE};
      default:        uw = '{A_NONE,   C_JUMP,     STEP_IDLE};
    endcase
    return uw;
  endfunction

  function automatic pc_t dispatch(op_t op);
    pc_t pc;
    case (op)
      OP_BYTE: pc = STEP_BYTE;
      OP_IDLE: pc = STEP_CONV;
      OP_TICK: pc = STEP_SCAN;
      default: pc = STEP_IDLE;
    endcase
    return pc;
  endfunction

  // bit0 = segment a .. bit6 = segment g
  function automatic logic [6:0] seg_pattern(logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/ssd_seq.sv
// ----------------------------------------------------------------------------
// ssd_seq: microcode sequencer
// Step counter over the control ROM, with opcode dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module ssd_seq (
  input  logic                clk,
  input  logic                rst,
  input  ssd_pkg::seq_status_t status,
  output ssd_pkg::seq_ctrl_t   ctrl
);

  ssd_pkg::pc_t    pc;
  ssd_pkg::pc_t    pc_next;
  ssd_pkg::uword_t uw;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ssd_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    uw        = ssd_pkg::ucode(pc);
    pc_next   = ssd_pkg::pc_t'(pc + 4'd1);
    ctrl.act  = uw.act;
    ctrl.busy = (pc != ssd_pkg::STEP_IDLE);
    case (uw.cond)
      ssd_pkg::C_NEXT: ;
      ssd_pkg::C_JUMP: pc_next = uw.target;
      ssd_pkg::C_DISPATCH: begin
        pc_next = status.accept ? ssd_pkg::dispatch(status.op) : ssd_pkg::STEP_IDLE;
      end
      ssd_pkg::C_IDX_DONE: begin
        if (status.idx_done) pc_next = uw.target;
      end
      ssd_pkg::C_IDX_AT_K: begin
        if (status.idx_at_k) pc_next = uw.target;
      end
      ssd_pkg::C_WAIT_OUT: begin
        // hold here, action suppressed, until the output register frees up
        if (status.out_free) begin
          pc_next = uw.target;
        end else begin
          pc_next  = pc;
          ctrl.act = ssd_pkg::A_NONE;
        end
      end
      default: pc_next = ssd_pkg::STEP_IDLE;
    endcase
  end

endmodule

>>> rtl/serial_decimal_seven_segment_display.sv
// ----------------------------------------------------------------------------
// serial_decimal_seven_segment_display: ASCII decimal to multiplexed display
// One request at a time, in_stall high while it runs. A byte is stored; a
// line idle converts the n stored bytes (at most 4) with one multiply-accumulate
// per byte; a scan tick reaches its registered result through k divide-by-ten
// steps (k = scan digit, at most 3), one per microcode pass;
// a tick also holds while the previous result is still stalled at the output.
// Sync reset clears counts, shown value, scan digit, sequencer and out_valid.
// ----------------------------------------------------------------------------
module serial_decimal_seven_segment_display (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  digit_enable_n,
  output logic [6:0]  segments,
  output logic [15:0] shown_number
);

  ssd_pkg::seq_status_t status;
  ssd_pkg::seq_ctrl_t   ctrl;

  logic [7:0]  byte_reg;
  logic [7:0]  digit_store [ssd_pkg::STORE_DEPTH];
  logic [2:0]  received_count;
  logic [2:0]  store_position;
  logic [15:0] shown_value;
  logic [ssd_pkg::SCAN_W-1:0] scan_digit;
  logic [15:0] acc;
  logic [2:0]  idx;
  logic [2:0]  n_reg;
  logic [15:0] work;

  logic        accept;
  logic [31:0] div_prod;
  logic [12:0] div_quot;
  logic [15:0] div_rem;
  logic [15:0] term;

  assign accept   = in_valid && !ctrl.busy;
  assign in_stall = ctrl.busy;

  assign status.accept   = accept;
  assign status.op       = ssd_pkg::op_t'(op);
  assign status.idx_done = (idx == n_reg);
  assign status.idx_at_k = (idx == 3'(scan_digit));
  assign status.out_free = !out_valid || !out_stall;

  ssd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // x/10 = (x * 0xCCCD) >> 19, exact over 16 bits
  always_comb begin
    div_prod = 32'(work) * 32'd52429;
    div_quot = div_prod[31:19];
    div_rem  = work - 16'({div_quot, 3'b000}) - 16'({div_quot, 1'b0});
    term     = 16'(digit_store[idx[1:0]]) - 16'(ssd_pkg::ASCII_ZERO);
  end

  always_ff @(posedge clk) begin
    if (accept) byte_reg <= rx_byte;
    if (ctrl.act == ssd_pkg::A_STORE && store_position < 3'(ssd_pkg::STORE_DEPTH)) begin
      digit_store[store_position[1:0]] <= byte_reg;
    end
    case (ctrl.act)
      ssd_pkg::A_CLEAR: begin
        acc   <= '0;
        idx   <= '0;
        n_reg <= (received_count > 3'(ssd_pkg::STORE_DEPTH)) ?
                 3'(ssd_pkg::STORE_DEPTH) : received_count;
      end
      ssd_pkg::A_MAC: begin
        // Horner step: acc*10 + digit, wraps at 16 bits
        acc <= (acc << 3) + (acc << 1) + term;
        idx <= idx + 3'd1;
      end
      ssd_pkg::A_LOAD: begin
        work <= shown_value;
        idx  <= '0;
      end
      ssd_pkg::A_DIV: begin
        work <= 16'(div_quot);
        idx  <= idx + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_count <= '0;
      store_position <= '0;
      shown_value    <= '0;
      scan_digit     <= '0;
    end else begin
      case (ctrl.act)
        ssd_pkg::A_STORE: begin
          if (store_position < 3'(ssd_pkg::STORE_DEPTH)) store_position <= store_position + 3'd1;
          if (received_count < 3'(ssd_pkg::COUNT_MAX)) received_count <= received_count + 3'd1;
        end
        ssd_pkg::A_COMMIT: begin
          shown_value    <= acc;
          received_count <= '0;
          store_position <= '0;
        end
        ssd_pkg::A_EMIT: begin
          if (scan_digit == ssd_pkg::SCAN_W'(ssd_pkg::DIGITS - 1)) begin
            scan_digit <= '0;
          end else begin
            scan_digit <= scan_digit + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.act == ssd_pkg::A_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ssd_pkg::A_EMIT) begin
      // shifting past bit 3 leaves all enables high
      digit_enable_n <= ~(4'd1 << scan_digit);
      segments       <= ssd_pkg::seg_pattern(div_rem[3:0]);
      shown_number   <= shown_value;
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    store_position <= 3'(ssd_pkg::STORE_DEPTH))
    else $error("store position past store depth");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    received_count <= 3'(ssd_pkg::COUNT_MAX))
    else $error("received count past saturation");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op != ssd_pkg::OP_NONE |=> in_stall)
    else $error("request accepted but sequencer not busy");

  a_one_cold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(digit_enable_n) >= 3)
    else $error("more than one digit enabled");
`endif

endmodule

>>> sim/tb_serial_decimal_seven_segment_display.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_decimal_seven_segment_display: self-checking bench for the display
// Drives byte, line-idle, scan-tick and unused requests in random bursts, with
// a stalling receiver and one long hold-off. A local predictor of the byte
// store, decimal conversion and digit scan supplies the expected scan results.
// ----------------------------------------------------------------------------
module tb_serial_decimal_seven_segment_display;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TOTAL_ITEMS  = 1500;
  localparam int DIR_ROWS     = 24;

  typedef struct {
    logic [3:0]  enable_n;
    logic [6:0]  segs;
    logic [15:0] number;
  } scan_result_t;

  typedef struct {
    ssd_pkg::op_t req_op;
    logic [7:0]   req_byte;
    bit           has_want;
    scan_result_t want;
  } stim_row_t;

  // segment patterns for decimal digits, bit0 = a
  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_stall;
  ssd_pkg::op_t op = ssd_pkg::OP_BYTE;
  logic [7:0]   rx_byte = 8'h00;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [3:0]   digit_enable_n;
  logic [6:0]   segments;
  logic [15:0]  shown_number;

  serial_decimal_seven_segment_display u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_enable_n (digit_enable_n),
    .segments       (segments),
    .shown_number   (shown_number)
  );

  // predictor state
  logic [7:0]                 byte_store [ssd_pkg::STORE_DEPTH];
  logic [2:0]                 rx_count  = '0;
  logic [2:0]                 store_pos = '0;
  logic [15:0]                shown_val = '0;
  logic [ssd_pkg::SCAN_W-1:0] scan_pos  = '0;

  scan_result_t expected_scans [$];
  scan_result_t blank_result = '{default: '0};
  stim_row_t    dir_rows [DIR_ROWS];

  int  mismatches = 0;
  int  sent = 0;
  int  burst_left = 0;
  int  cycles = 0;
  logic hold_off = 1'b0;
  int  stall_mode = 0;
  int  stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_scans.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  function automatic logic [15:0] decimal_value();
    int n;
    logic [15:0] acc;
    logic [15:0] term;
    n = (rx_count > ssd_pkg::STORE_DEPTH) ? ssd_pkg::STORE_DEPTH : int'(rx_count);
    acc = '0;
    for (int i = 0; i < n; i++) begin
      term = 16'(byte_store[i]) - 16'(ssd_pkg::ASCII_ZERO);
      for (int j = 1; j < n - i; j++)
        term = term * 16'd10;
      acc = acc + term;
    end
    return acc;
  endfunction

  function automatic void apply_request(ssd_pkg::op_t o, logic [7:0] b,
                                        output bit produced, output scan_result_t r);
    int k;
    logic [15:0] v;
    produced = 1'b0;
    r = '{default: '0};
    case (o)
      ssd_pkg::OP_BYTE: begin
        if (store_pos < ssd_pkg::STORE_DEPTH) begin
          byte_store[store_pos] = b;
          store_pos++;
        end
        if (rx_count < ssd_pkg::COUNT_MAX)
          rx_count++;
      end
      ssd_pkg::OP_IDLE: begin
        shown_val = decimal_value();
        rx_count  = '0;
        store_pos = '0;
      end
      ssd_pkg::OP_TICK: begin
        k = int'(scan_pos);
        if (k >= ssd_pkg::DIGITS)
          k = 0;
        v = shown_val;
        for (int i = 0; i < k; i++)
          v = v / 16'd10;
        r.enable_n = (k < 4) ? ~(4'b0001 << k) : 4'hF;
        r.segs     = DIGIT_SEGS[v % 16'd10];
        r.number   = shown_val;
        scan_pos   = ssd_pkg::SCAN_W'((k + 1) % ssd_pkg::DIGITS);
        produced   = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // sender: bursts of requests separated by random gaps
  task automatic issue_request(ssd_pkg::op_t o, logic [7:0] b, bit has_want,
                               scan_result_t want);
    int gap;
    bit produced;
    scan_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      op       <= ssd_pkg::op_t'($urandom_range(0, 3));
      rx_byte  <= 8'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    op       <= o;
    rx_byte  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    apply_request(o, b, produced, predicted);
    if (produced)
      expected_scans.push_back(has_want ? want : predicted);
    if (o != ssd_pkg::OP_NONE)
      sent++;
  endtask

  // receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       out_stall <= hold_off;
        1:       out_stall <= hold_off || ($urandom_range(0, 1) == 0);
        2:       out_stall <= hold_off || ($urandom_range(0, 4) != 0);
        default: out_stall <= hold_off || (cycles % 3 != 0);
      endcase
    end
  end

  // long hold-off so the block backs up and stalls its input
  initial begin
    repeat (4000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (500) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    scan_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_scans.size() == 0) begin
        flag_mismatch("unexpected result", shown_number, 0);
      end else begin
        w = expected_scans.pop_front();
        if (digit_enable_n !== w.enable_n)
          flag_mismatch("digit_enable_n", digit_enable_n, w.enable_n);
        if (segments !== w.segs)
          flag_mismatch("segments", segments, w.segs);
        if (shown_number !== w.number)
          flag_mismatch("shown_number", shown_number, w.number);
      end
    end
  end

  initial begin
    int pick;
    int n;
    dir_rows = '{
      '{ssd_pkg::OP_TICK, 8'h00, 1'b1, '{4'hE, 7'h3F, 16'd0}},     // scan after reset
      '{ssd_pkg::OP_TICK, 8'hFF, 1'b1, '{4'hD, 7'h3F, 16'd0}},
      '{ssd_pkg::OP_TICK, 8'h00, 1'b1, '{4'hB, 7'h3F, 16'd0}},
      '{ssd_pkg::OP_TICK, 8'hFF, 1'b1, '{4'h7, 7'h3F, 16'd0}},     // scan wraps next
      '{ssd_pkg::OP_BYTE, 8'h39, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_BYTE, 8'h39, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_BYTE, 8'h39, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_BYTE, 8'h39, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_BYTE, 8'h39, 1'b0, '{default: '0}},            // store full
      '{ssd_pkg::OP_BYTE, 8'h39, 1'b0, '{default: '0}},            // count saturates
      '{ssd_pkg::OP_IDLE, 8'h00, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_TICK, 8'h00, 1'b1, '{4'hE, 7'h6F, 16'd9999}},
      '{ssd_pkg::OP_TICK, 8'h00, 1'b1, '{4'hD, 7'h6F, 16'd9999}},
      '{ssd_pkg::OP_BYTE, 8'hFF, 1'b0, '{default: '0}},            // non-digit bytes wrap
      '{ssd_pkg::OP_BYTE, 8'h00, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_IDLE, 8'hFF, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_TICK, 8'h00, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_IDLE, 8'h00, 1'b0, '{default: '0}},            // empty request
      '{ssd_pkg::OP_TICK, 8'h00, 1'b1, '{4'h7, 7'h3F, 16'd0}},
      '{ssd_pkg::OP_NONE, 8'hAA, 1'b0, '{default: '0}},            // unused opcode
      '{ssd_pkg::OP_BYTE, 8'h2F, 1'b0, '{default: '0}},            // one below '0'
      '{ssd_pkg::OP_IDLE, 8'h55, 1'b0, '{default: '0}},
      '{ssd_pkg::OP_TICK, 8'h00, 1'b1, '{4'hE, 7'h6D, 16'd65535}},
      '{ssd_pkg::OP_TICK, 8'hFF, 1'b1, '{4'hD, 7'h4F, 16'd65535}}
    };

    while (rst) @(posedge clk);

    foreach (dir_rows[i])
      issue_request(dir_rows[i].req_op, dir_rows[i].req_byte, dir_rows[i].has_want,
                    dir_rows[i].want);

    while (sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // well-formed number: digits, line idle, then a few scans
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        repeat (n)
          issue_request(ssd_pkg::OP_BYTE,
                        ssd_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)),
                        1'b0, blank_result);
        issue_request(ssd_pkg::OP_IDLE, 8'($urandom), 1'b0, blank_result);
        repeat ($urandom_range(1, 6))
          issue_request(ssd_pkg::OP_TICK, 8'($urandom), 1'b0, blank_result);
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 8))
          issue_request(ssd_pkg::OP_TICK, 8'($urandom), 1'b0, blank_result);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6))
          issue_request(ssd_pkg::OP_BYTE, 8'($urandom), 1'b0, blank_result);
        if ($urandom_range(0, 1) == 1)
          issue_request(ssd_pkg::OP_IDLE, 8'($urandom), 1'b0, blank_result);
      end else if ($urandom_range(0, 1) == 1) begin
        issue_request(ssd_pkg::OP_NONE, 8'($urandom), 1'b0, blank_result);
      end else begin
        issue_request(ssd_pkg::OP_IDLE, 8'($urandom), 1'b0, blank_result);
      end
    end

    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0 && expected_scans.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> serial_decimal_seven_segment_display.f
rtl/ssd_pkg.sv
rtl/ssd_seq.sv
rtl/serial_decimal_seven_segment_display.sv
sim/tb_serial_decimal_seven_segment_display.sv
